// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the page replacement core.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/cprmmu_pkg.sv =====
// Types and constants of the clock page replacement core.
// No dependencies; imported by clock_page_replacement_mmu_core.
`default_nettype none
package cprmmu_pkg;
  localparam int unsigned FRAME_COUNT       = 32;
  localparam int unsigned PAGE_BYTES        = 16;
  localparam int unsigned PROCESS_COUNT     = 16;
  localparam int unsigned PAGES_PER_PROCESS = 32;
  localparam int unsigned TABLE_SIZE        = PROCESS_COUNT * PAGES_PER_PROCESS;

  localparam int unsigned FW = $clog2(FRAME_COUNT);
  localparam int unsigned PW = $clog2(PAGES_PER_PROCESS);
  localparam int unsigned QW = $clog2(PROCESS_COUNT);
  localparam int unsigned EW = $clog2(TABLE_SIZE);
  localparam int unsigned OW = $clog2(PAGE_BYTES);

  localparam logic [1:0] CMD_ACCESS  = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_ADMIT   = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAULT  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  localparam logic [5:0] LIMIT_MAX = 6'(PAGES_PER_PROCESS);

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] process;
    logic [8:0] virtual_address;
    logic       is_write;
    logic [5:0] page_count;
  } cpr_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] frame;
    logic       evicted;
    logic [3:0] evicted_process;
    logic [4:0] evicted_page;
    logic       write_back;
  } cpr_out_t;

  typedef struct packed {
    logic          valid;
    logic          referenced;
    logic          dirty;
    logic [FW-1:0] frame;
  } pte_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_SWEEP_RD, S_SWEEP_CK, S_FILL, S_DROP, S_RESP
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/core/clock_page_replacement_mmu_core.sv =====
// Clock (second chance) page replacement core: page table memory and frame table.
// Depends on cprmmu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// One item is worked at a time. After reset a clearing pass writes all 512
// page table entries, one per cycle, with the input stalled. An access, or a
// load of a resident page, reads the page table entry, modifies and writes it
// back, then responds. A load into a free frame takes the same steps; with no
// frame free the clock hand reads and then checks one page table entry per
// frame passed over (at most one full turn) before the new entry is filled.
// Admit and release clear the process's 32 entries, one per cycle. The result
// waits in an output register, so a new item is taken while it is stalled.
module clock_page_replacement_mmu_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  cprmmu_pkg::cpr_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output cprmmu_pkg::cpr_out_t out_data_o
);
  import cprmmu_pkg::*;

  pte_t          mem [TABLE_SIZE];
  pte_t          rdata_q;
  logic [EW-1:0] raddr;
  logic          we;
  logic [EW-1:0] waddr;
  pte_t          wdata;

  state_e            state_q, state_d;
  cpr_in_t           req_q, req_d;
  cpr_out_t          res_q, res_d;
  cpr_out_t          out_q;
  logic              out_valid_q;
  logic [EW-1:0]     cnt_q, cnt_d;
  logic [FW-1:0]     hand_q, hand_d;
  logic [FW-1:0]     fsel_q, fsel_d;
  logic [FRAME_COUNT-1:0] in_use_q, in_use_d;
  logic [QW-1:0]     owner_q [FRAME_COUNT];
  logic [PW-1:0]     fpage_q [FRAME_COUNT];
  logic [5:0]        limit_q [PROCESS_COUNT];
  logic              tbl_we;
  logic              lim_we;

  logic [PW-1:0]     in_page, req_page;
  logic [EW-1:0]     req_entry;
  logic              beyond, any_free, is_mem_cmd, take_out;
  logic [FW-1:0]     free_idx;

  assign in_page   = in_data_i.virtual_address[OW +: PW];
  assign req_page  = req_q.virtual_address[OW +: PW];
  assign req_entry = {req_q.process, req_page};
  assign beyond    = {1'b0, req_page} >= limit_q[req_q.process];
  assign any_free  = ~&in_use_q;
  assign is_mem_cmd = (req_q.command == CMD_ACCESS) || (req_q.command == CMD_LOAD);
  assign take_out  = !out_valid_q || !out_stall_i;

  always_comb begin
    free_idx = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) free_idx = FW'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (cnt_q == EW'(TABLE_SIZE - 1)) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        if (!is_mem_cmd) state_d = S_DROP;
        else if (beyond || rdata_q.valid || req_q.command == CMD_ACCESS) state_d = S_RESP;
        else if (any_free) state_d = S_RESP;
        else state_d = S_SWEEP_RD;
      end
      S_SWEEP_RD: state_d = S_SWEEP_CK;
      S_SWEEP_CK: state_d = rdata_q.referenced ? S_SWEEP_RD : S_FILL;
      S_FILL: state_d = S_RESP;
      S_DROP: if (cnt_q[PW-1:0] == PW'(PAGES_PER_PROCESS - 1)) state_d = S_RESP;
      S_RESP: if (take_out) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    req_d    = req_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    hand_d   = hand_q;
    fsel_d   = fsel_q;
    in_use_d = in_use_q;
    tbl_we   = 1'b0;
    lim_we   = 1'b0;
    we       = 1'b0;
    waddr    = req_entry;
    wdata    = '0;
    raddr    = {in_data_i.process, in_page};
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + 1'b1;
      end
      S_IDLE: begin
        req_d = in_data_i;
        res_d = '0;
        cnt_d = '0;
      end
      S_LOOK: begin
        if (!is_mem_cmd) begin
          for (int i = 0; i < FRAME_COUNT; i++) begin
            if (owner_q[i] == req_q.process) in_use_d[i] = 1'b0;
          end
          lim_we = (req_q.command == CMD_ADMIT);
        end else if (beyond) begin
          res_d.status = ST_BEYOND;
        end else if (rdata_q.valid) begin
          we = 1'b1;
          wdata = rdata_q;
          wdata.referenced = 1'b1;
          wdata.dirty = rdata_q.dirty | (req_q.command == CMD_ACCESS && req_q.is_write);
          res_d.frame = 5'(rdata_q.frame);
        end else if (req_q.command == CMD_ACCESS) begin
          res_d.status = ST_FAULT;
        end else if (any_free) begin
          we = 1'b1;
          wdata = '{valid: 1'b1, referenced: 1'b1, dirty: 1'b0, frame: free_idx};
          fsel_d = free_idx;
          tbl_we = 1'b1;
          in_use_d[free_idx] = 1'b1;
          res_d.frame = 5'(free_idx);
        end
      end
      S_SWEEP_RD: raddr = {owner_q[hand_q], fpage_q[hand_q]};
      S_SWEEP_CK: begin
        we     = 1'b1;
        waddr  = {owner_q[hand_q], fpage_q[hand_q]};
        hand_d = FW'((32'(hand_q) + 1) % FRAME_COUNT);
        if (rdata_q.referenced) begin
          wdata = rdata_q;
          wdata.referenced = 1'b0;
        end else begin
          wdata = '0;
          fsel_d = hand_q;
          res_d.evicted = 1'b1;
          res_d.evicted_process = 4'(owner_q[hand_q]);
          res_d.evicted_page = 5'(fpage_q[hand_q]);
          res_d.write_back = rdata_q.dirty;
        end
      end
      S_FILL: begin
        we = 1'b1;
        wdata = '{valid: 1'b1, referenced: 1'b1, dirty: 1'b0, frame: fsel_q};
        tbl_we = 1'b1;
        in_use_d[fsel_q] = 1'b1;
        res_d.frame = 5'(fsel_q);
      end
      S_DROP: begin
        we    = 1'b1;
        waddr = {req_q.process, cnt_q[PW-1:0]};
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    fsel_q <= fsel_d;
    if (tbl_we) begin
      owner_q[fsel_d] <= req_q.process;
      fpage_q[fsel_d] <= req_page;
    end
    if (state_q == S_RESP && take_out) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      hand_q      <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PROCESS_COUNT; i++) limit_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hand_q   <= hand_d;
      in_use_q <= in_use_d;
      if (lim_we) begin
        limit_q[req_q.process] <= (req_q.page_count > LIMIT_MAX) ? LIMIT_MAX
                                                                 : req_q.page_count;
      end
      if (state_q == S_RESP && take_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_AT(a_clear_stalls, clk_i, rst_ni, (state_q == S_CLEAR) |-> in_stall_o)
  `ASSERT_AT(a_status_code, clk_i, rst_ni, out_valid_o |-> (out_data_o.status == ST_OK ||
    out_data_o.status == ST_FAULT || out_data_o.status == ST_BEYOND))
  `ASSERT_NEVER(a_wb_needs_evict, clk_i, rst_ni,
    out_valid_o && out_data_o.write_back && !out_data_o.evicted)
  `ASSERT_AT(a_accept_starts, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == S_LOOK))
  `ASSERT_AT(a_sweep_full, clk_i, rst_ni, (state_q == S_SWEEP_RD) |-> (in_use_q == '1))
endmodule
`default_nettype wire
